[src/assert_macros.svh]
// assertion helpers for the lift controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SLMC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define SLMC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[src/slmc_pkg.sv]
package slmc_pkg;

  localparam int LevelBits     = 10;
  localparam int FractionBits  = 16;
  localparam int PosBits       = LevelBits + FractionBits;
  localparam int MsBits        = 16;
  localparam int DwellBits     = MsBits + 1;
  localparam int QuoBits       = MsBits + FractionBits;
  localparam int EventBits     = 2;
  localparam int CfgIndexBits  = 3;
  localparam int CfgDataBits   = 16;
  localparam int MaxPhaseSteps = 4;
  localparam int StepBits      = 3;

  localparam logic [LevelBits-1:0] TopLevelRst    = LevelBits'(1);
  localparam logic [LevelBits-1:0] BottomLevelRst = LevelBits'(0);
  localparam logic [LevelBits-1:0] StartLevelRst  = LevelBits'(0);
  localparam logic [MsBits-1:0]    UpMsRst        = MsBits'(1000);
  localparam logic [MsBits-1:0]    DownMsRst      = MsBits'(1000);
  localparam logic [MsBits-1:0]    TopDwellRst    = MsBits'(1000);
  localparam logic [MsBits-1:0]    BottomDwellRst = MsBits'(1000);
  localparam logic                 EnableRst      = 1'b1;

  typedef enum logic [1:0] {
    PH_UP     = 2'd0,
    PH_DOWN   = 2'd1,
    PH_TOP    = 2'd2,
    PH_BOTTOM = 2'd3
  } phase_e;

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_TOP_LEVEL    = 3'd0,
    CFG_BOTTOM_LEVEL = 3'd1,
    CFG_START_LEVEL  = 3'd2,
    CFG_UP_MS        = 3'd3,
    CFG_DOWN_MS      = 3'd4,
    CFG_TOP_DWELL    = 3'd5,
    CFG_BOTTOM_DWELL = 3'd6,
    CFG_ENABLE       = 3'd7
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic              mode;
    logic [MsBits-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [PosBits-1:0]   position;
    logic [LevelBits-1:0] whole_level;
    phase_e               phase;
    logic [MsBits-1:0]    dwell_left_ms;
    logic [EventBits-1:0] moved_events;
  } out_item_t;

  typedef struct packed {
    logic [LevelBits-1:0] top_level;
    logic [LevelBits-1:0] bottom_level;
    logic [LevelBits-1:0] start_level;
    logic [MsBits-1:0]    up_ms_per_level;
    logic [MsBits-1:0]    down_ms_per_level;
    logic [MsBits-1:0]    top_dwell_ms;
    logic [MsBits-1:0]    bottom_dwell_ms;
    logic                 enable;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic dwell_step;
    logic div_start;
    logic move_apply;
  } dp_cmd_t;

  typedef struct packed {
    logic ms_zero;
    logic moving;
    logic frozen;
    logic div_done;
  } dp_status_t;

endpackage

[src/slmc_div.sv]
module slmc_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [slmc_pkg::MsBits-1:0]          ms_i,
  input  logic [slmc_pkg::MsBits-1:0]          divisor_i,
  output logic                                 done_o,
  output logic [slmc_pkg::QuoBits-1:0]         quotient_o
);

  localparam int CntBits = $clog2(slmc_pkg::QuoBits);

  logic [slmc_pkg::QuoBits-1:0] num_q, num_d;
  logic [slmc_pkg::MsBits-1:0]  rem_q, rem_d;
  logic [slmc_pkg::MsBits-1:0]  div_q, div_d;
  logic [CntBits-1:0]           cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;

  logic [slmc_pkg::MsBits:0]    trial;
  logic [slmc_pkg::MsBits:0]    trial_sub;
  logic                         fits;
  logic                         last;

  // one quotient bit per cycle, restoring
  assign trial     = {rem_q, num_q[slmc_pkg::QuoBits-1]};
  assign fits      = trial >= {1'b0, div_q};
  assign trial_sub = trial - {1'b0, div_q};
  assign last      = cnt_q == CntBits'(slmc_pkg::QuoBits - 1);

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = {ms_i, slmc_pkg::FractionBits'(0)};
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[slmc_pkg::QuoBits-2:0], fits};
      rem_d = fits ? trial_sub[slmc_pkg::MsBits-1:0] : trial[slmc_pkg::MsBits-1:0];
      cnt_d = cnt_q + CntBits'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

[src/slmc_datapath.sv]
module slmc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  slmc_pkg::cfg_t                cfg_i,
  input  slmc_pkg::dp_cmd_t             cmd_i,
  input  logic [slmc_pkg::MsBits-1:0]   elapsed_ms_i,
  output slmc_pkg::dp_status_t          status_o,
  output slmc_pkg::out_item_t           result_o
);

  localparam int PB = slmc_pkg::PosBits;
  localparam int FB = slmc_pkg::FractionBits;
  localparam int LB = slmc_pkg::LevelBits;
  localparam int MB = slmc_pkg::MsBits;
  localparam int DB = slmc_pkg::DwellBits;
  localparam int QB = slmc_pkg::QuoBits;
  localparam int EB = slmc_pkg::EventBits;

  logic [PB-1:0]           pos_q, pos_d;
  slmc_pkg::phase_e        phase_q, phase_d;
  logic [DB-1:0]           dwell_q, dwell_d;
  logic [MB-1:0]           ms_q, ms_d;
  logic [LB-1:0]           start_whole_q, start_whole_d;
  logic [EB-1:0]           events_q, events_d;

  logic [PB-1:0]           top_pos;
  logic [PB-1:0]           bottom_pos;
  logic [PB-1:0]           start_pos;
  slmc_pkg::phase_e        restart_phase;
  logic [DB-1:0]           restart_dwell;

  logic [MB-1:0]           speed;
  logic [MB-1:0]           divisor;
  logic                    div_done;
  logic [QB-1:0]           quotient;

  logic [QB:0]             up_sum;
  logic                    up_over;
  logic signed [QB+1:0]    down_diff;
  logic                    down_under;
  logic [DB:0]             dwell_diff;
  logic [DB:0]             dwell_neg;
  logic                    dwell_ran_out;
  logic                    in_dwell;

  assign top_pos    = {cfg_i.top_level, FB'(0)};
  assign bottom_pos = {cfg_i.bottom_level, FB'(0)};
  assign start_pos  = {cfg_i.start_level, FB'(0)};

  assign restart_phase = (cfg_i.top_level < cfg_i.start_level) ?
                         slmc_pkg::PH_TOP : slmc_pkg::PH_BOTTOM;
  assign restart_dwell = (cfg_i.top_level < cfg_i.start_level) ?
                         {1'b0, cfg_i.top_dwell_ms} : {1'b0, cfg_i.bottom_dwell_ms};

  // zero speed counts as one
  assign speed   = (phase_q == slmc_pkg::PH_DOWN) ? cfg_i.down_ms_per_level
                                                  : cfg_i.up_ms_per_level;
  assign divisor = (speed == '0) ? MB'(1) : speed;

  slmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .ms_i       (ms_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign up_sum     = (QB+1)'(pos_q) + (QB+1)'(quotient);
  assign up_over    = up_sum > (QB+1)'(top_pos);
  assign down_diff  = $signed((QB+2)'(pos_q)) - $signed((QB+2)'(quotient));
  assign down_under = down_diff < $signed((QB+2)'(bottom_pos));

  assign dwell_diff    = {dwell_q[DB-1], dwell_q} - {2'b00, ms_q};
  assign dwell_neg     = -dwell_diff;
  assign dwell_ran_out = dwell_diff[DB];

  always_comb begin
    pos_d         = pos_q;
    phase_d       = phase_q;
    dwell_d       = dwell_q;
    ms_d          = ms_q;
    start_whole_d = start_whole_q;
    events_d      = events_q;

    if (cmd_i.load) begin
      ms_d          = elapsed_ms_i;
      start_whole_d = pos_q[PB-1 -: LB];
      events_d      = '0;
    end

    if (cmd_i.restart) begin
      pos_d   = start_pos;
      phase_d = restart_phase;
      dwell_d = restart_dwell;
    end

    if (cmd_i.dwell_step) begin
      dwell_d = dwell_diff[DB-1:0];
      if (dwell_ran_out) begin
        ms_d = dwell_neg[MB-1:0];
        if (phase_q == slmc_pkg::PH_TOP) begin
          if (pos_q <= bottom_pos) begin
            phase_d = slmc_pkg::PH_BOTTOM;
            dwell_d = {1'b0, cfg_i.bottom_dwell_ms};
          end else begin
            phase_d = slmc_pkg::PH_DOWN;
          end
        end else begin
          if (pos_q >= top_pos) begin
            phase_d = slmc_pkg::PH_TOP;
            dwell_d = {1'b0, cfg_i.top_dwell_ms};
          end else begin
            phase_d  = slmc_pkg::PH_UP;
            events_d = events_q + EB'(1);
          end
        end
      end else begin
        ms_d = '0;
      end
    end

    if (cmd_i.move_apply) begin
      ms_d = '0;
      if (phase_q == slmc_pkg::PH_UP) begin
        if (up_over) begin
          pos_d   = top_pos;
          phase_d = slmc_pkg::PH_TOP;
          dwell_d = {1'b0, cfg_i.top_dwell_ms};
        end else begin
          pos_d = up_sum[PB-1:0];
          if (up_sum[FB +: LB] != start_whole_q) begin
            events_d = events_q + EB'(1);
          end
        end
      end else begin
        if (down_under) begin
          pos_d   = bottom_pos;
          phase_d = slmc_pkg::PH_BOTTOM;
          dwell_d = {1'b0, cfg_i.bottom_dwell_ms};
        end else begin
          pos_d = down_diff[PB-1:0];
          if (down_diff[FB +: LB] != start_whole_q) begin
            events_d = events_q + EB'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= {slmc_pkg::StartLevelRst, FB'(0)};
      phase_q  <= (slmc_pkg::TopLevelRst < slmc_pkg::StartLevelRst) ?
                  slmc_pkg::PH_TOP : slmc_pkg::PH_BOTTOM;
      dwell_q  <= (slmc_pkg::TopLevelRst < slmc_pkg::StartLevelRst) ?
                  {1'b0, slmc_pkg::TopDwellRst} : {1'b0, slmc_pkg::BottomDwellRst};
      events_q <= '0;
    end else begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      dwell_q  <= dwell_d;
      events_q <= events_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ms_q          <= ms_d;
    start_whole_q <= start_whole_d;
  end

  assign in_dwell = (phase_q == slmc_pkg::PH_TOP) || (phase_q == slmc_pkg::PH_BOTTOM);

  assign status_o.ms_zero  = ms_q == '0;
  assign status_o.moving   = !in_dwell;
  assign status_o.frozen   = (cfg_i.top_level == cfg_i.bottom_level) && (pos_q == bottom_pos);
  assign status_o.div_done = div_done;

  assign result_o.position      = pos_q;
  assign result_o.whole_level   = pos_q[PB-1 -: LB];
  assign result_o.phase         = phase_q;
  assign result_o.dwell_left_ms = (in_dwell && !dwell_q[DB-1] && dwell_q != '0) ?
                                  dwell_q[MB-1:0] : '0;
  assign result_o.moved_events  = events_q;

endmodule

[src/slmc_ctrl.sv]
module slmc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  mode_i,
  input  logic                  enable_i,
  input  logic                  out_free_i,
  input  slmc_pkg::dp_status_t  status_i,
  output logic                  in_ready_o,
  output slmc_pkg::dp_cmd_t     cmd_o,
  output logic                  out_load_o
);

  localparam int SB = slmc_pkg::StepBits;

  slmc_pkg::ctrl_state_e state_q, state_d;
  logic [SB-1:0]         step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    unique case (state_q)
      slmc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          priority if (mode_i) begin
            cmd_o.restart = 1'b1;
            state_d       = slmc_pkg::ST_OUT;
          end else if (!enable_i || status_i.frozen) begin
            state_d = slmc_pkg::ST_OUT;
          end else begin
            state_d = slmc_pkg::ST_STEP;
          end
        end
      end
      slmc_pkg::ST_STEP: begin
        priority if (status_i.ms_zero || step_q == SB'(slmc_pkg::MaxPhaseSteps)) begin
          state_d = slmc_pkg::ST_OUT;
        end else if (status_i.moving) begin
          cmd_o.div_start = 1'b1;
          state_d         = slmc_pkg::ST_DIV;
        end else begin
          cmd_o.dwell_step = 1'b1;
          step_d           = step_q + SB'(1);
        end
      end
      slmc_pkg::ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.move_apply = 1'b1;
          step_d           = step_q + SB'(1);
          state_d          = slmc_pkg::ST_STEP;
        end
      end
      slmc_pkg::ST_OUT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = slmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = slmc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slmc_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

[src/shuttle_lift_motion_controller.sv]
// shuttle lift motion controller
// input channel (in_valid_i/in_ready_o, in_item_i): a tick item with elapsed ms
// or a restart item. output channel (out_valid_o/out_ready_i, out_item_o):
// one result item per input item, giving position, whole level, phase,
// remaining dwell and the count of start-up and level-crossing events.
// configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i at once.
// one item at a time. restart, disabled and frozen ticks go from acceptance
// straight to the result; any other tick first runs its dwell steps and
// moves, each move through the 32-step shift-subtract divider that turns
// elapsed time into distance. at most two dwell steps come before a move.
// the next item is accepted the cycle after a result enters the output
// register, so a stalled receiver holds only one finished item while the
// block takes and works on the next; the block waits to hand over its
// following result until the output register is free.
// reset restores the default registers and puts the lift at the start level,
// dwelling at the bottom, with no result pending.
`include "assert_macros.svh"

module shuttle_lift_motion_controller (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  slmc_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output slmc_pkg::out_item_t                  out_item_o,
  input  logic                                 cfg_we_i,
  input  logic [slmc_pkg::CfgIndexBits-1:0]    cfg_index_i,
  input  logic [slmc_pkg::CfgDataBits-1:0]     cfg_wdata_i
);

  localparam int LB = slmc_pkg::LevelBits;
  localparam int MB = slmc_pkg::MsBits;

  slmc_pkg::cfg_t       cfg_q, cfg_d;
  slmc_pkg::dp_cmd_t    dp_cmd;
  slmc_pkg::dp_status_t dp_status;
  slmc_pkg::out_item_t  result;
  slmc_pkg::out_item_t  out_q;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;
  logic                 out_load;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (slmc_pkg::cfg_index_e'(cfg_index_i))
        slmc_pkg::CFG_TOP_LEVEL:    cfg_d.top_level         = cfg_wdata_i[LB-1:0];
        slmc_pkg::CFG_BOTTOM_LEVEL: cfg_d.bottom_level      = cfg_wdata_i[LB-1:0];
        slmc_pkg::CFG_START_LEVEL:  cfg_d.start_level       = cfg_wdata_i[LB-1:0];
        slmc_pkg::CFG_UP_MS:        cfg_d.up_ms_per_level   = cfg_wdata_i[MB-1:0];
        slmc_pkg::CFG_DOWN_MS:      cfg_d.down_ms_per_level = cfg_wdata_i[MB-1:0];
        slmc_pkg::CFG_TOP_DWELL:    cfg_d.top_dwell_ms      = cfg_wdata_i[MB-1:0];
        slmc_pkg::CFG_BOTTOM_DWELL: cfg_d.bottom_dwell_ms   = cfg_wdata_i[MB-1:0];
        slmc_pkg::CFG_ENABLE:       cfg_d.enable            = cfg_wdata_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.top_level         <= slmc_pkg::TopLevelRst;
      cfg_q.bottom_level      <= slmc_pkg::BottomLevelRst;
      cfg_q.start_level       <= slmc_pkg::StartLevelRst;
      cfg_q.up_ms_per_level   <= slmc_pkg::UpMsRst;
      cfg_q.down_ms_per_level <= slmc_pkg::DownMsRst;
      cfg_q.top_dwell_ms      <= slmc_pkg::TopDwellRst;
      cfg_q.bottom_dwell_ms   <= slmc_pkg::BottomDwellRst;
      cfg_q.enable            <= slmc_pkg::EnableRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  slmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (in_item_i.mode),
    .enable_i   (cfg_q.enable),
    .out_free_i (out_free),
    .status_i   (dp_status),
    .in_ready_o (in_ready_o),
    .cmd_o      (dp_cmd),
    .out_load_o (out_load)
  );

  slmc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (dp_cmd),
    .elapsed_ms_i (in_item_i.elapsed_ms),
    .status_o     (dp_status),
    .result_o     (result)
  );

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `SLMC_ASSERT_IMPL(a_load_free_slot, clk_i, rst_ni, out_load, !out_valid_q || out_ready_i)
  `SLMC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `SLMC_ASSERT_IMPL(a_div_only_moving, clk_i, rst_ni, dp_cmd.div_start, dp_status.moving && !dp_status.ms_zero)
  `SLMC_ASSERT_IMPL(a_move_after_div, clk_i, rst_ni, dp_cmd.move_apply, dp_status.div_done)

endmodule

[bench/testbench.sv]
module testbench;
  import slmc_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  in_item_t                in_item = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_item_t               out_item;
  logic                    cfg_we = 1'b0;
  logic [CfgIndexBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0]  cfg_wdata = '0;

  int  errors = 0;
  int  item_count = 0;
  int  restart_count = 0;
  int  settings_count = 0;
  int  event_total = 0;
  int  hold_left = 0;
  bit  steady = 1'b0;

  cfg_t      shadow_cfg;
  longint    shadow_pos;
  phase_e    shadow_phase;
  int        shadow_dwell;
  out_item_t awaited_reports[$];

  shuttle_lift_motion_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic cfg_t make_cfg(int top, int bottom, int start, int up_ms, int down_ms,
                                    int top_dwell, int bottom_dwell, int en);
    cfg_t c;
    c.top_level         = LevelBits'(top);
    c.bottom_level      = LevelBits'(bottom);
    c.start_level       = LevelBits'(start);
    c.up_ms_per_level   = MsBits'(up_ms);
    c.down_ms_per_level = MsBits'(down_ms);
    c.top_dwell_ms      = MsBits'(top_dwell);
    c.bottom_dwell_ms   = MsBits'(bottom_dwell);
    c.enable            = en[0];
    return c;
  endfunction

  function automatic void restart_shadow();
    shadow_pos = longint'(shadow_cfg.start_level) <<< FractionBits;
    if (shadow_cfg.top_level < shadow_cfg.start_level) begin
      shadow_phase = PH_TOP;
      shadow_dwell = int'(shadow_cfg.top_dwell_ms);
    end else begin
      shadow_phase = PH_BOTTOM;
      shadow_dwell = int'(shadow_cfg.bottom_dwell_ms);
    end
  endfunction

  // zero speed behaves as one ms per level
  function automatic longint travel(int ms, logic [MsBits-1:0] ms_per_level);
    longint divisor;
    divisor = (ms_per_level == '0) ? 64'sd1 : longint'(ms_per_level);
    return (longint'(ms) <<< FractionBits) / divisor;
  endfunction

  function automatic out_item_t next_lift_report(in_item_t item);
    int        ms;
    int        events;
    longint    top_pos;
    longint    bottom_pos;
    longint    start_whole;
    out_item_t rep;
    events      = 0;
    ms          = int'(item.elapsed_ms);
    top_pos     = longint'(shadow_cfg.top_level) <<< FractionBits;
    bottom_pos  = longint'(shadow_cfg.bottom_level) <<< FractionBits;
    start_whole = shadow_pos >>> FractionBits;
    if (item.mode) begin
      restart_shadow();
    end else if (shadow_cfg.enable &&
                 !(shadow_cfg.top_level == shadow_cfg.bottom_level && shadow_pos == bottom_pos)) begin
      for (int step = 0; step < MaxPhaseSteps && ms > 0; step++) begin
        case (shadow_phase)
          PH_UP: begin
            shadow_pos += travel(ms, shadow_cfg.up_ms_per_level);
            if (shadow_pos > top_pos) begin
              shadow_pos   = top_pos;
              shadow_phase = PH_TOP;
              shadow_dwell = int'(shadow_cfg.top_dwell_ms);
            end else if ((shadow_pos >>> FractionBits) != start_whole) begin
              events++;
            end
            ms = 0;
          end
          PH_DOWN: begin
            shadow_pos -= travel(ms, shadow_cfg.down_ms_per_level);
            if (shadow_pos < bottom_pos) begin
              shadow_pos   = bottom_pos;
              shadow_phase = PH_BOTTOM;
              shadow_dwell = int'(shadow_cfg.bottom_dwell_ms);
            end else if ((shadow_pos >>> FractionBits) != start_whole) begin
              events++;
            end
            ms = 0;
          end
          PH_TOP: begin
            shadow_dwell = shadow_dwell - ms;
            if (shadow_dwell < 0) begin
              ms = -shadow_dwell;
              if (shadow_pos <= bottom_pos) begin
                shadow_phase = PH_BOTTOM;
                shadow_dwell = int'(shadow_cfg.bottom_dwell_ms);
              end else begin
                shadow_phase = PH_DOWN;
              end
            end else begin
              ms = 0;
            end
          end
          default: begin
            shadow_dwell = shadow_dwell - ms;
            if (shadow_dwell < 0) begin
              ms = -shadow_dwell;
              if (shadow_pos >= top_pos) begin
                shadow_phase = PH_TOP;
                shadow_dwell = int'(shadow_cfg.top_dwell_ms);
              end else begin
                shadow_phase = PH_UP;
                events++;
              end
            end else begin
              ms = 0;
            end
          end
        endcase
      end
    end
    rep.position      = shadow_pos[PosBits-1:0];
    rep.whole_level   = shadow_pos[PosBits-1:FractionBits];
    rep.phase         = shadow_phase;
    rep.dwell_left_ms = ((shadow_phase == PH_TOP || shadow_phase == PH_BOTTOM) &&
                         shadow_dwell > 0) ? shadow_dwell[MsBits-1:0] : '0;
    rep.moved_events  = events[EventBits-1:0];
    return rep;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_reports
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_reports.size() == 0) begin
        $error("result with nothing awaited: position %0d", out_item.position);
        errors++;
      end else begin
        want = awaited_reports.pop_front();
        check_field("position", 32'(want.position), 32'(out_item.position));
        check_field("whole_level", 32'(want.whole_level), 32'(out_item.whole_level));
        check_field("phase", 32'(want.phase), 32'(out_item.phase));
        check_field("dwell_left_ms", 32'(want.dwell_left_ms), 32'(out_item.dwell_left_ms));
        check_field("moved_events", 32'(want.moved_events), 32'(out_item.moved_events));
      end
    end
  end

  // receiver with random stalls and requested hold-offs
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 34);
    end
  end

  task automatic send_item(input in_item_t item);
    out_item_t rep;
    if (!steady && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!steady && $urandom_range(99) < 34);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rep = next_lift_report(item);
    awaited_reports = {awaited_reports, rep};
    item_count++;
    event_total += int'(rep.moved_events);
    if (item.mode) restart_count++;
  endtask

  task automatic send_tick(input int ms);
    send_item(in_item_t'{mode: 1'b0, elapsed_ms: MsBits'(ms)});
  endtask

  task automatic send_restart();
    send_item(in_item_t'{mode: 1'b1, elapsed_ms: MsBits'($urandom_range(65535))});
  endtask

  task automatic wait_for_reports();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [CfgDataBits-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(CFG_TOP_LEVEL, CfgDataBits'(c.top_level));
    write_reg(CFG_BOTTOM_LEVEL, CfgDataBits'(c.bottom_level));
    write_reg(CFG_START_LEVEL, CfgDataBits'(c.start_level));
    write_reg(CFG_UP_MS, c.up_ms_per_level);
    write_reg(CFG_DOWN_MS, c.down_ms_per_level);
    write_reg(CFG_TOP_DWELL, c.top_dwell_ms);
    write_reg(CFG_BOTTOM_DWELL, c.bottom_dwell_ms);
    write_reg(CFG_ENABLE, CfgDataBits'(c.enable));
    cfg_we <= 1'b0;
    shadow_cfg = c;
    settings_count++;
  endtask

  function automatic logic [MsBits-1:0] random_elapsed();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return MsBits'($urandom_range(3));
    if (pick < 55) return MsBits'($urandom_range(400));
    if (pick < 85) return MsBits'($urandom_range(5000));
    return MsBits'($urandom_range(65535));
  endfunction

  function automatic int random_duration();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return 0;
    if (pick < 35) return $urandom_range(20, 1);
    if (pick < 80) return $urandom_range(2000, 1);
    return $urandom_range(65535, 1);
  endfunction

  function automatic cfg_t random_settings();
    int lo;
    int hi;
    int start;
    int pick;
    lo   = $urandom_range(1023);
    pick = $urandom_range(99);
    if (pick < 65) hi = (lo + 8 > 1023) ? 1023 : lo + $urandom_range(8, 1);
    else if (pick < 80) hi = $urandom_range(1023, lo);
    else if (pick < 95) hi = $urandom_range(lo);
    else hi = lo;
    if ($urandom_range(1)) start = (hi >= lo) ? $urandom_range(hi, lo) : $urandom_range(lo, hi);
    else start = $urandom_range(1023);
    return make_cfg(hi, lo, start, random_duration(), random_duration(),
                    random_duration(), random_duration(), int'($urandom_range(99) < 92));
  endfunction

  task automatic test_reset_defaults();
    send_tick(0);
    send_tick(999);
    send_tick(1);
    send_tick(1);
    send_tick(65535);
    send_restart();
    send_tick(32768);
    wait_for_reports();
  endtask

  task automatic test_zero_speed();
    apply_settings(make_cfg(1023, 0, 0, 0, 0, 0, 0, 1));
    send_restart();
    send_tick(1);
    send_tick(65535);
    send_tick(65535);
    wait_for_reports();
  endtask

  // ends moved under a lift already in motion, then a disabled lift
  task automatic test_moving_register_change();
    apply_settings(make_cfg(10, 0, 5, 1000, 1000, 1000, 0, 1));
    send_restart();
    send_tick(500);
    send_tick(700);
    wait_for_reports();
    apply_settings(make_cfg(3, 0, 5, 1000, 1000, 1000, 0, 1));
    send_tick(100);
    wait_for_reports();
    apply_settings(make_cfg(3, 0, 5, 1000, 1000, 1000, 0, 0));
    send_tick(5000);
    send_restart();
    wait_for_reports();
  endtask

  task automatic test_frozen_lift();
    apply_settings(make_cfg(7, 7, 7, 1000, 1000, 1000, 1000, 1));
    send_restart();
    send_tick(1000);
    send_tick(65535);
    wait_for_reports();
  endtask

  // top below bottom: dwells swap back and forth until the step limit
  task automatic test_endless_exchange();
    apply_settings(make_cfg(2, 5, 3, 1000, 1000, 10, 10, 1));
    send_restart();
    send_tick(100);
    send_tick(65535);
    wait_for_reports();
  endtask

  task automatic test_backpressure();
    apply_settings(make_cfg(20, 0, 0, 50, 50, 30, 30, 1));
    steady    = 1'b1;
    hold_left = 300;
    for (int i = 0; i < 40; i++) begin
      send_tick(random_elapsed());
    end
    wait_for_reports();
    steady = 1'b0;
  endtask

  task automatic test_random_settings();
    int count;
    for (int ph = 0; ph < 10; ph++) begin
      wait_for_reports();
      if (ph == 0) begin
        apply_settings(make_cfg(0, 0, 0, 0, 0, 0, 0, 0));
        count = 40;
      end else if (ph == 1) begin
        apply_settings(make_cfg(1023, 0, 1023, 65535, 65535, 65535, 65535, 1));
        count = 40;
      end else begin
        apply_settings(random_settings());
        count = 170;
      end
      steady = (ph == 4);
      if ($urandom_range(1)) send_restart();
      for (int i = 0; i < count; i++) begin
        if (i == count / 2) wait_for_reports();
        send_item(in_item_t'{mode: ($urandom_range(99) < 6), elapsed_ms: random_elapsed()});
      end
      steady = 1'b0;
    end
    wait_for_reports();
  endtask

  initial begin
    shadow_cfg = make_cfg(int'(TopLevelRst), int'(BottomLevelRst), int'(StartLevelRst),
                          int'(UpMsRst), int'(DownMsRst), int'(TopDwellRst),
                          int'(BottomDwellRst), int'(EnableRst));
    restart_shadow();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_zero_speed();
    test_moving_register_change();
    test_frozen_lift();
    test_endless_exchange();
    test_backpressure();
    test_random_settings();
    wait_for_reports();
    repeat (50) @(posedge clk);
    $display("ran %0d items, %0d of them restarts, under %0d register settings",
             item_count, restart_count, settings_count);
    $display("lift reported %0d start-up and level-crossing events", event_total);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
